// ===== rtl/ddhd_pkg.sv =====
// ddhd_pkg: shared types, constants and the code-length order table
// for the deflate dynamic header decoder core and its submodules.
// no dependencies.
package ddhd_pkg;

	localparam int CL_LOOKUP_BITS_DEF = 7;
	localparam int CL_SYMS = 19;
	localparam int QDEPTH = 4;
	localparam logic [8:0] LIT_BASE = 9'd257;
	localparam logic [4:0] CL_EMPTY = 5'd31;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_TYPE = 3'd1;
	localparam logic [2:0] ERR_CODE = 3'd2;
	localparam logic [2:0] ERR_NOPREV = 3'd3;
	localparam logic [2:0] ERR_OVERRUN = 3'd4;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_RUN = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic start;
	} byte_item_t;

	typedef struct packed {
		kind_t kind;
		logic tsel;
		logic [8:0] first;
		logic [7:0] run;
		logic [3:0] len;
		logic [8:0] lit;
		logic [5:0] dcnt;
		logic fin;
		logic [2:0] err;
		logic done;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ok;
	} tbl_status_t;

	// permuted order of the code-length code lengths
	function automatic logic [4:0] cl_order_f(input logic [4:0] i);
		logic [4:0] r;
		case (i)
			5'd0: r = 5'd16;
			5'd1: r = 5'd17;
			5'd2: r = 5'd18;
			5'd3: r = 5'd0;
			5'd4: r = 5'd8;
			5'd5: r = 5'd7;
			5'd6: r = 5'd9;
			5'd7: r = 5'd6;
			5'd8: r = 5'd10;
			5'd9: r = 5'd5;
			5'd10: r = 5'd11;
			5'd11: r = 5'd4;
			5'd12: r = 5'd12;
			5'd13: r = 5'd3;
			5'd14: r = 5'd13;
			5'd15: r = 5'd2;
			5'd16: r = 5'd14;
			5'd17: r = 5'd1;
			5'd18: r = 5'd15;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/deflate_dynamic_header_decoder_core.sv =====
// deflate_dynamic_header_decoder_core: top level of the dynamic header decoder.
// depends on ddhd_pkg, ddhd_front, ddhd_table and ddhd_back.
//
// Takes compressed bytes (bits used lsb first) and parses a deflate block header:
// bfinal and btype, then hlit, hdist and hclen, the code-length code lengths,
// and the literal/length and distance code lengths as runs. Set s_tuser to 1 on
// the byte that opens a header; other bytes seen while idle are dropped. Each
// output transfer is header info, a run of lengths or an error; m_tlast marks
// the last transfer of a header or any error. Stored, fixed and reserved blocks
// give an unsupported-type error. A four-entry byte queue sits in front
// of the parser, so input and output stall independently. While the output is
// free, the parser takes one field, one code-length entry or one repeat per
// cycle; a symbol is looked up in the code-length table through a registered
// memory read. Once per header the table build runs through count, first codes,
// memory clear and fill; that build and the single write port of the lookup
// memory set the header cost.
module deflate_dynamic_header_decoder_core #(
	parameter int CL_LOOKUP_BITS = ddhd_pkg::CL_LOOKUP_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,   // [7:0] data_byte
	input logic [0:0] s_tuser,   // [0] start_req
	output logic m_tvalid,
	input logic m_tready,
	output logic [39:0] m_tdata, // [8:0] first_index, [16:9] run_count,
	                             // [20:17] code_length, [29:21] literal_count,
	                             // [35:30] distance_count, [36] final_block,
	                             // [39:37] error_code
	output logic [2:0] m_tuser,  // [1:0] out_kind, [2] table_select
	output logic m_tlast         // header_done
);
	import ddhd_pkg::*;

	// queue between input side and parser
	byte_item_t item;
	logic item_valid;
	logic item_ready;

	// lookup table build and read
	logic build;
	logic [CL_SYMS-1:0][2:0] cl_len;
	logic [CL_LOOKUP_BITS-1:0] rd_addr;
	logic [7:0] rd_data;
	tbl_status_t tbl_st;

	result_t res;

	ddhd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.item(item),
		.item_valid(item_valid),
		.item_ready(item_ready)
	);

	ddhd_table #(.LB(CL_LOOKUP_BITS)) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.build(build),
		.cl_len(cl_len),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.status(tbl_st)
	);

	ddhd_back #(.LB(CL_LOOKUP_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.build(build),
		.cl_len(cl_len),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.tbl_st(tbl_st),
		.res(res),
		.res_valid(m_tvalid),
		.res_ready(m_tready)
	);

	// pack the result transfer
	assign m_tdata = {res.err, res.fin, res.dcnt, res.lit, res.len, res.run, res.first};
	assign m_tuser = {res.tsel, res.kind};
	assign m_tlast = res.done;

	// every error transfer closes the header
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_ERROR) |-> m_tlast)
		else $error("error transfer without header_done");

	// a run transfer never carries an empty run
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_RUN) |-> (m_tdata[16:9] != 8'd0))
		else $error("run transfer with zero count");

	// header info always reports a literal count of at least 257
	a_hdr_lit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_HEADER) |-> (m_tdata[29:21] >= LIT_BASE))
		else $error("header transfer with short literal count");

endmodule

// ===== rtl/ddhd_front.sv =====
// ddhd_front: input side, takes byte transfers and queues them for the parser.
// depends on ddhd_pkg.
module ddhd_front (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,
	input logic [0:0] s_tuser,
	output ddhd_pkg::byte_item_t item,
	output logic item_valid,
	input logic item_ready
);
	import ddhd_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	byte_item_t mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] cnt_q;
	logic push;
	logic pop;

	assign s_tready = (cnt_q != (PW+1)'(QDEPTH));
	assign item_valid = (cnt_q != '0);
	assign item = mem_q[rd_ptr_q];
	assign push = s_tvalid && s_tready;
	assign pop = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: s_tdata, start: s_tuser[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/ddhd_table.sv =====
// ddhd_table: canonical lookup builder for the code-length code and its memory.
// depends on ddhd_pkg.
module ddhd_table #(
	parameter int LB = ddhd_pkg::CL_LOOKUP_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic build,
	input logic [ddhd_pkg::CL_SYMS-1:0][2:0] cl_len,
	input logic [LB-1:0] rd_addr,
	output logic [7:0] rd_data,
	output ddhd_pkg::tbl_status_t status
);
	import ddhd_pkg::*;

	localparam int DEPTH = 1 << LB;
	localparam int KW = LB + 5;

	typedef enum logic [2:0] {T_IDLE, T_COUNT, T_NEXT, T_CLEAR, T_FILL} tst_t;

	tst_t st_q;
	logic [4:0] n_q;
	logic [4:0] cnt_q [8];
	logic [7:0] nxt_q [8];
	logic [7:0] code_q;
	logic [2:0] b_q;
	logic [KW-1:0] kraft_q;
	logic [LB-1:0] addr_q;
	logic [LB-1:0] j_q;
	logic done_q;
	logic ok_q;

	logic [7:0] mem_q [DEPTH];

	logic [2:0] cur_len;
	logic [KW-1:0] kraft_nx;
	logic [7:0] code_n;
	logic [7:0] cur_code;
	logic [6:0] rev7;
	logic [6:0] rev;
	logic [LB+6:0] fa_w;
	logic [LB-1:0] fill_addr;
	logic j_last;
	logic we;
	logic [LB-1:0] wa;
	logic [7:0] wd;

	always_comb begin
		cur_len = cl_len[n_q];
		kraft_nx = kraft_q + ((cur_len != 3'd0) ? (KW'(1) << (LB - int'(cur_len))) : '0);
		code_n = (code_q + 8'(cnt_q[b_q - 3'd1])) << 1;
		cur_code = nxt_q[cur_len];
		for (int k = 0; k < 7; k++) rev7[k] = cur_code[6-k];
		rev = rev7 >> (3'd7 - cur_len);
		fa_w = (LB+7)'(rev) | ((LB+7)'(j_q) << cur_len);
		fill_addr = fa_w[LB-1:0];
		j_last = (j_q == LB'((1 << (LB - int'(cur_len))) - 1));
		we = (st_q == T_CLEAR) || (st_q == T_FILL && cur_len != 3'd0);
		wa = (st_q == T_CLEAR) ? addr_q : fill_addr;
		wd = (st_q == T_CLEAR) ? {3'd0, CL_EMPTY} : {cur_len, n_q};
	end

	assign status = '{busy: (st_q != T_IDLE), done: done_q, ok: ok_q};

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_data <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			n_q <= '0;
			for (int i = 0; i < 8; i++) begin
				cnt_q[i] <= '0;
				nxt_q[i] <= '0;
			end
			code_q <= '0;
			b_q <= '0;
			kraft_q <= '0;
			addr_q <= '0;
			j_q <= '0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			case (st_q)
				T_IDLE: begin
					if (build) begin
						n_q <= '0;
						kraft_q <= '0;
						for (int i = 0; i < 8; i++) cnt_q[i] <= '0;
						done_q <= 1'b0;
						ok_q <= 1'b0;
						st_q <= T_COUNT;
					end
				end
				T_COUNT: begin
					if (cur_len != 3'd0) cnt_q[cur_len] <= cnt_q[cur_len] + 5'd1;
					kraft_q <= kraft_nx;
					if (n_q == 5'(CL_SYMS - 1)) begin
						if (kraft_nx > KW'(DEPTH)) begin
							done_q <= 1'b1;
							st_q <= T_IDLE;
						end else begin
							b_q <= 3'd1;
							code_q <= '0;
							st_q <= T_NEXT;
						end
					end else begin
						n_q <= n_q + 5'd1;
					end
				end
				T_NEXT: begin
					nxt_q[b_q] <= code_n;
					code_q <= code_n;
					if (b_q == 3'd7) begin
						addr_q <= '0;
						st_q <= T_CLEAR;
					end else begin
						b_q <= b_q + 3'd1;
					end
				end
				T_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LB'(DEPTH - 1)) begin
						n_q <= '0;
						j_q <= '0;
						st_q <= T_FILL;
					end
				end
				T_FILL: begin
					if (cur_len == 3'd0 || j_last) begin
						j_q <= '0;
						if (cur_len != 3'd0) nxt_q[cur_len] <= nxt_q[cur_len] + 8'd1;
						if (n_q == 5'(CL_SYMS - 1)) begin
							done_q <= 1'b1;
							ok_q <= 1'b1;
							st_q <= T_IDLE;
						end else begin
							n_q <= n_q + 5'd1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ddhd_back.sv =====
// ddhd_back: header parser, bit buffer, symbol decode and result register.
// depends on ddhd_pkg; drives ddhd_table through its build and read ports.
module ddhd_back #(
	parameter int LB = ddhd_pkg::CL_LOOKUP_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input ddhd_pkg::byte_item_t item,
	input logic item_valid,
	output logic item_ready,
	output logic build,
	output logic [ddhd_pkg::CL_SYMS-1:0][2:0] cl_len,
	output logic [LB-1:0] rd_addr,
	input logic [7:0] rd_data,
	input ddhd_pkg::tbl_status_t tbl_st,
	output ddhd_pkg::result_t res,
	output logic res_valid,
	input logic res_ready
);
	import ddhd_pkg::*;

	typedef enum logic [1:0] {B_POP, B_PARSE, B_SPLIT, B_BUILD} bst_t;
	typedef enum logic [2:0] {
		PH_IDLE, PH_TYPE, PH_HLIT, PH_HDIST, PH_HCLEN, PH_CLLEN, PH_SYMS
	} ph_t;
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_16 = 2'd1;
	localparam logic [1:0] PEND_17 = 2'd2;
	localparam logic [1:0] PEND_18 = 2'd3;

	bst_t bst_q;
	ph_t ph_q;
	logic [15:0] buf_q;
	logic [4:0] held_q;
	logic [8:0] lit_q;
	logic [5:0] dist_q;
	logic [4:0] clen_q;
	logic [CL_SYMS-1:0][2:0] cl_len_q;
	logic [8:0] idx_q;
	logic [3:0] prev_q;
	logic prev_ok_q;
	logic [1:0] pend_q;
	logic fin_q;
	logic [3:0] cnt_q;
	logic lk_ok_q;
	logic build_q;
	logic [7:0] split_run_q;
	logic [3:0] split_len_q;
	logic split_done_q;
	result_t res_q;
	logic res_valid_q;

	logic out_free;
	logic [15:0] base_buf;
	logic [4:0] base_held;
	logic [15:0] app_buf;
	logic [4:0] app_held;
	logic [2:0] rep_extra;
	logic [6:0] rep_v;
	logic [7:0] rep_n;
	logic [3:0] rep_len;
	logic [4:0] lk_sym;
	logic [2:0] lk_len;
	logic [7:0] run_n;
	logic [3:0] run_len;
	logic [9:0] total;
	logic [9:0] end_idx;
	logic split;
	logic in_dist;
	logic [7:0] part;
	logic run_done;
	logic rep_go;
	logic sym_go;
	logic run_go;

	function automatic result_t mk(input kind_t k, input logic t, input logic [8:0] f,
			input logic [7:0] r, input logic [3:0] l, input logic [8:0] li,
			input logic [5:0] d, input logic fn, input logic [2:0] e, input logic dn);
		result_t x;
		x = '{kind: k, tsel: t, first: f, run: r, len: l, lit: li, dcnt: d,
			fin: fn, err: e, done: dn};
		return x;
	endfunction

	always_comb begin
		out_free = !res_valid_q || res_ready;
		base_buf = (held_q > 5'd8) ? {8'd0, buf_q[7:0]} : buf_q;
		base_held = (held_q > 5'd8) ? 5'd8 : held_q;
		app_buf = base_buf | ({8'd0, item.data} << base_held);
		app_held = base_held + 5'd8;
		case (pend_q)
			PEND_16: rep_extra = 3'd2;
			PEND_17: rep_extra = 3'd3;
			default: rep_extra = 3'd7;
		endcase
		rep_v = buf_q[6:0] & ((7'd1 << rep_extra) - 7'd1);
		rep_n = (pend_q == PEND_18) ? 8'd11 + {1'b0, rep_v} : 8'd3 + {1'b0, rep_v};
		rep_len = (pend_q == PEND_16) ? prev_q : 4'd0;
		lk_sym = rd_data[4:0];
		lk_len = rd_data[7:5];
		run_n = (pend_q != PEND_NONE) ? rep_n : 8'd1;
		run_len = (pend_q != PEND_NONE) ? rep_len : lk_sym[3:0];
		total = {1'b0, lit_q} + 10'(dist_q);
		end_idx = {1'b0, idx_q} + 10'(run_n);
		split = (idx_q < lit_q) && (end_idx > {1'b0, lit_q});
		in_dist = (idx_q >= lit_q);
		part = 8'(lit_q - idx_q);
		run_done = (end_idx >= total);
		rep_go = (pend_q != PEND_NONE) && (held_q >= {2'd0, rep_extra})
			&& !(pend_q == PEND_16 && !prev_ok_q) && !(end_idx > total);
		sym_go = (pend_q == PEND_NONE) && lk_ok_q && (lk_sym != CL_EMPTY)
			&& (lk_len != 3'd0) && ({2'd0, lk_len} <= held_q) && (lk_sym < 5'd16);
		run_go = (bst_q == B_PARSE) && out_free && (ph_q == PH_SYMS)
			&& (cnt_q <= 4'd8) && (rep_go || sym_go);
	end

	assign item_ready = (bst_q == B_POP);
	assign build = build_q;
	assign cl_len = cl_len_q;
	assign rd_addr = buf_q[LB-1:0];
	assign res = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (run_go) begin
			split_run_q <= 8'(run_n - part);
			split_len_q <= run_len;
			split_done_q <= run_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_POP;
			ph_q <= PH_IDLE;
			buf_q <= '0;
			held_q <= '0;
			lit_q <= '0;
			dist_q <= '0;
			clen_q <= '0;
			cl_len_q <= '0;
			idx_q <= '0;
			prev_q <= '0;
			prev_ok_q <= 1'b0;
			pend_q <= PEND_NONE;
			fin_q <= 1'b0;
			cnt_q <= '0;
			lk_ok_q <= 1'b0;
			build_q <= 1'b0;
			res_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			build_q <= 1'b0;
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (!(bst_q == B_PARSE && !out_free)) lk_ok_q <= 1'b0;
			case (bst_q)
				B_POP: begin
					if (item_valid) begin
						cnt_q <= '0;
						if (item.start) begin
							ph_q <= PH_TYPE;
							cl_len_q <= '0;
							idx_q <= '0;
							prev_q <= '0;
							prev_ok_q <= 1'b0;
							fin_q <= 1'b0;
							pend_q <= PEND_NONE;
							buf_q <= {8'd0, item.data};
							held_q <= 5'd8;
							bst_q <= B_PARSE;
						end else if (ph_q != PH_IDLE) begin
							buf_q <= app_buf;
							held_q <= app_held;
							bst_q <= B_PARSE;
						end
					end
				end
				B_PARSE: begin
					if (out_free) begin
						case (ph_q)
							PH_TYPE: begin
								if (held_q < 5'd3) begin
									bst_q <= B_POP;
								end else if (buf_q[2:1] != 2'd2) begin
									res_q <= mk(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0,
										buf_q[0], ERR_TYPE, 1'b1);
									res_valid_q <= 1'b1;
									fin_q <= buf_q[0];
									ph_q <= PH_IDLE;
									buf_q <= '0;
									held_q <= '0;
									pend_q <= PEND_NONE;
									bst_q <= B_POP;
								end else begin
									fin_q <= buf_q[0];
									buf_q <= buf_q >> 3;
									held_q <= held_q - 5'd3;
									ph_q <= PH_HLIT;
								end
							end
							PH_HLIT: begin
								if (held_q < 5'd5) begin
									bst_q <= B_POP;
								end else begin
									lit_q <= LIT_BASE + 9'(buf_q[4:0]);
									buf_q <= buf_q >> 5;
									held_q <= held_q - 5'd5;
									ph_q <= PH_HDIST;
								end
							end
							PH_HDIST: begin
								if (held_q < 5'd5) begin
									bst_q <= B_POP;
								end else begin
									dist_q <= 6'd1 + 6'(buf_q[4:0]);
									buf_q <= buf_q >> 5;
									held_q <= held_q - 5'd5;
									ph_q <= PH_HCLEN;
								end
							end
							PH_HCLEN: begin
								if (held_q < 5'd4) begin
									bst_q <= B_POP;
								end else begin
									clen_q <= 5'd4 + 5'(buf_q[3:0]);
									res_q <= mk(KIND_HEADER, 1'b0, '0, '0, '0, lit_q, dist_q,
										fin_q, ERR_NONE, 1'b0);
									res_valid_q <= 1'b1;
									cnt_q <= cnt_q + 4'd1;
									idx_q <= '0;
									buf_q <= buf_q >> 4;
									held_q <= held_q - 5'd4;
									ph_q <= PH_CLLEN;
								end
							end
							PH_CLLEN: begin
								if (held_q < 5'd3) begin
									bst_q <= B_POP;
								end else begin
									if (idx_q < 9'(CL_SYMS)) begin
										cl_len_q[cl_order_f(idx_q[4:0])] <= buf_q[2:0];
									end
									idx_q <= idx_q + 9'd1;
									buf_q <= buf_q >> 3;
									held_q <= held_q - 5'd3;
									if (idx_q + 9'd1 >= 9'(clen_q)) begin
										build_q <= 1'b1;
										bst_q <= B_BUILD;
									end
								end
							end
							PH_SYMS: begin
								if (cnt_q > 4'd8) begin
									bst_q <= B_POP;
								end else if (pend_q != PEND_NONE) begin
									if (held_q < {2'd0, rep_extra}) begin
										bst_q <= B_POP;
									end else if ((pend_q == PEND_16 && !prev_ok_q)
											|| (end_idx > total)) begin
										res_q <= mk(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, fin_q,
											(pend_q == PEND_16 && !prev_ok_q) ? ERR_NOPREV
											: ERR_OVERRUN, 1'b1);
										res_valid_q <= 1'b1;
										ph_q <= PH_IDLE;
										buf_q <= '0;
										held_q <= '0;
										pend_q <= PEND_NONE;
										bst_q <= B_POP;
									end else begin
										prev_q <= rep_len;
										prev_ok_q <= 1'b1;
										pend_q <= PEND_NONE;
										buf_q <= buf_q >> rep_extra;
										held_q <= held_q - 5'(rep_extra);
									end
								end else if (!lk_ok_q) begin
									lk_ok_q <= 1'b1;
								end else if (lk_sym == CL_EMPTY) begin
									if (held_q >= 5'(LB)) begin
										res_q <= mk(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, fin_q,
											ERR_CODE, 1'b1);
										res_valid_q <= 1'b1;
										ph_q <= PH_IDLE;
										buf_q <= '0;
										held_q <= '0;
										pend_q <= PEND_NONE;
									end
									bst_q <= B_POP;
								end else if (lk_len == 3'd0 || {2'd0, lk_len} > held_q) begin
									bst_q <= B_POP;
								end else begin
									buf_q <= buf_q >> lk_len;
									held_q <= held_q - 5'(lk_len);
									if (lk_sym < 5'd16) begin
										prev_q <= lk_sym[3:0];
										prev_ok_q <= 1'b1;
									end else begin
										pend_q <= lk_sym[1:0] + 2'd3 - 2'd2;
									end
								end
							end
							default: bst_q <= B_POP;
						endcase
					end
				end
				B_SPLIT: begin
					if (out_free) begin
						res_q <= mk(KIND_RUN, 1'b1, '0, split_run_q, split_len_q, '0, '0,
							1'b0, ERR_NONE, split_done_q);
						res_valid_q <= 1'b1;
						cnt_q <= cnt_q + 4'd1;
						if (split_done_q) begin
							ph_q <= PH_IDLE;
							buf_q <= '0;
							held_q <= '0;
							pend_q <= PEND_NONE;
						end
						bst_q <= B_PARSE;
					end
				end
				B_BUILD: begin
					if (!build_q && !tbl_st.busy && tbl_st.done) begin
						if (tbl_st.ok) begin
							idx_q <= '0;
							prev_ok_q <= 1'b0;
							pend_q <= PEND_NONE;
							ph_q <= PH_SYMS;
							bst_q <= B_PARSE;
						end else if (out_free) begin
							res_q <= mk(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, fin_q,
								ERR_CODE, 1'b1);
							res_valid_q <= 1'b1;
							ph_q <= PH_IDLE;
							buf_q <= '0;
							held_q <= '0;
							pend_q <= PEND_NONE;
							bst_q <= B_POP;
						end
					end
				end
				default: bst_q <= B_POP;
			endcase

			// a decoded length or repeat becomes one run, or two across the table edge
			if (run_go) begin
				idx_q <= end_idx[8:0];
				res_valid_q <= 1'b1;
				cnt_q <= cnt_q + 4'd1;
				if (split) begin
					res_q <= mk(KIND_RUN, 1'b0, idx_q, part, run_len, '0, '0, 1'b0,
						ERR_NONE, 1'b0);
					bst_q <= B_SPLIT;
				end else begin
					res_q <= mk(KIND_RUN, in_dist, in_dist ? 9'(idx_q - lit_q) : idx_q,
						run_n, run_len, '0, '0, 1'b0, ERR_NONE, run_done);
					if (run_done) begin
						ph_q <= PH_IDLE;
						buf_q <= '0;
						held_q <= '0;
						pend_q <= PEND_NONE;
						bst_q <= B_POP;
					end
				end
			end
		end
	end

endmodule

// ===== test/tb_deflate_dynamic_header_decoder_core.sv =====
// testbench for deflate_dynamic_header_decoder_core: drives well-formed and broken
// deflate block headers and checks every output transfer against a built-in predictor.
// depends on ddhd_pkg and the rtl of the core.
module tb_deflate_dynamic_header_decoder_core;
	import ddhd_pkg::*;

	typedef enum int {PH_IDLE, PH_TYPE, PH_HLIT, PH_HDIST, PH_HCLEN, PH_CLLEN, PH_SYMS} phase_t;
	typedef enum int {HM_NORMAL, HM_BADTYPE, HM_OVERSUB, HM_EMPTY, HM_REP_FIRST, HM_OVERRUN,
		HM_MAXCNT, HM_CUT} hdr_mode_t;

	localparam int CLB = CL_LOOKUP_BITS_DEF;
	localparam int LUT_SIZE = 1 << CLB;

	// header predictor and result store
	class hdr_scoreboard;
		int unsigned acc;
		int held;
		phase_t ph;
		int lit_n, dist_n, clen_n, idx, prev_len, pend, fin;
		bit prev_ok;
		int cl_len[CL_SYMS];
		int lut[LUT_SIZE];
		int step_cnt;
		result_t exp_q[$];
		int fails, checked, n_err, n_hdr, n_run;

		function new();
			acc = 0; held = 0; ph = PH_IDLE; lit_n = 0; dist_n = 0; clen_n = 0;
			idx = 0; prev_len = 0; prev_ok = 0; pend = 0; fin = 0;
			foreach (cl_len[i]) cl_len[i] = 0;
			foreach (lut[i]) lut[i] = 0;
			fails = 0; checked = 0; n_err = 0; n_hdr = 0; n_run = 0;
		endfunction

		function int take(int n);
			int v;
			v = acc & ((1 << n) - 1);
			acc = acc >> n;
			held -= n;
			return v;
		endfunction

		function void put(kind_t k, int tsel, int first, int run, int len, int lit, int dcnt,
			int f, logic [2:0] err, int done);
			result_t r;
			r.kind = k; r.tsel = tsel[0]; r.first = first[8:0]; r.run = run[7:0];
			r.len = len[3:0]; r.lit = lit[8:0]; r.dcnt = dcnt[5:0]; r.fin = f[0];
			r.err = err; r.done = done[0];
			exp_q.push_back(r);
			step_cnt++;
		endfunction

		function void go_idle();
			ph = PH_IDLE; acc = 0; held = 0; pend = 0;
		endfunction

		function void fail_with(logic [2:0] code);
			put(KIND_ERROR, 0, 0, 0, 0, 0, 0, fin, code, 1);
			go_idle();
		endfunction

		function void run_out(int n, int len);
			if (idx < lit_n && idx + n > lit_n) begin
				put(KIND_RUN, 0, idx, lit_n - idx, len, 0, 0, 0, ERR_NONE, 0);
				put(KIND_RUN, 1, 0, n - (lit_n - idx), len, 0, 0, 0, ERR_NONE, 0);
			end else if (idx >= lit_n) begin
				put(KIND_RUN, 1, idx - lit_n, n, len, 0, 0, 0, ERR_NONE, 0);
			end else begin
				put(KIND_RUN, 0, idx, n, len, 0, 0, 0, ERR_NONE, 0);
			end
			idx += n;
			if (idx >= lit_n + dist_n) begin
				exp_q[exp_q.size() - 1].done = 1'b1;
				go_idle();
			end
		endfunction

		// canonical code-length lookup, 0 when oversubscribed
		function bit build_lut();
			int cnt[8];
			int nxt[8];
			int code, kraft, len, c, rev;
			code = 0; kraft = 0;
			foreach (cnt[b]) begin cnt[b] = 0; nxt[b] = 0; end
			for (int n = 0; n < CL_SYMS; n++) begin
				cnt[cl_len[n] & 7]++;
				if (cl_len[n] != 0) kraft += 1 << (CLB - cl_len[n]);
			end
			if (kraft > LUT_SIZE) return 0;
			cnt[0] = 0;
			for (int b = 1; b < 8; b++) begin
				code = (code + cnt[b - 1]) << 1;
				nxt[b] = code;
			end
			foreach (lut[i]) lut[i] = CL_EMPTY;
			for (int n = 0; n < CL_SYMS; n++) begin
				len = cl_len[n] & 7;
				if (len == 0) continue;
				c = nxt[len]++;
				rev = 0;
				for (int b = 0; b < len; b++) rev |= ((c >> (len - 1 - b)) & 1) << b;
				for (int j = 0; j < (1 << (CLB - len)); j++)
					lut[(rev | (j << len)) & (LUT_SIZE - 1)] = n;
			end
			return 1;
		endfunction

		// note one accepted byte and queue what it should produce
		function void note_byte(bit [7:0] b, bit st);
			int v, sym, len, ext, n;
			step_cnt = 0;
			if (st) begin
				go_idle();
				ph = PH_TYPE;
				foreach (cl_len[i]) cl_len[i] = 0;
				idx = 0; prev_len = 0; prev_ok = 0; fin = 0;
			end
			if (ph == PH_IDLE) return;
			if (held > 8) begin
				held = 8;
				acc &= 'hFF;
			end
			acc |= b << held;
			held += 8;
			while (ph != PH_IDLE) begin
				if (ph == PH_TYPE) begin
					if (held < 3) break;
					fin = take(1);
					if (take(2) != 2) begin fail_with(ERR_TYPE); break; end
					ph = PH_HLIT;
				end else if (ph == PH_HLIT) begin
					if (held < 5) break;
					lit_n = 257 + take(5);
					ph = PH_HDIST;
				end else if (ph == PH_HDIST) begin
					if (held < 5) break;
					dist_n = 1 + take(5);
					ph = PH_HCLEN;
				end else if (ph == PH_HCLEN) begin
					if (held < 4) break;
					clen_n = 4 + take(4);
					put(KIND_HEADER, 0, 0, 0, 0, lit_n, dist_n, fin, ERR_NONE, 0);
					idx = 0;
					ph = PH_CLLEN;
				end else if (ph == PH_CLLEN) begin
					if (held < 3) break;
					v = take(3);
					if (idx < CL_SYMS) cl_len[cl_order_f(idx[4:0])] = v;
					idx++;
					if (idx >= clen_n) begin
						if (!build_lut()) begin fail_with(ERR_CODE); break; end
						idx = 0; prev_ok = 0; pend = 0;
						ph = PH_SYMS;
					end
				end else begin
					if (step_cnt > 8) break;
					if (pend != 0) begin
						ext = pend == 16 ? 2 : (pend == 17 ? 3 : 7);
						if (held < ext) break;
						v = take(ext);
						if (pend == 16) begin
							if (!prev_ok) begin fail_with(ERR_NOPREV); break; end
							n = 3 + v; len = prev_len;
						end else if (pend == 17) begin
							n = 3 + v; len = 0;
						end else begin
							n = 11 + v; len = 0;
						end
						pend = 0;
						if (idx + n > lit_n + dist_n) begin fail_with(ERR_OVERRUN); break; end
						prev_len = len; prev_ok = 1;
						run_out(n, len);
					end else begin
						sym = lut[acc & (LUT_SIZE - 1)];
						if (sym >= CL_SYMS) begin
							if (held >= CLB) fail_with(ERR_CODE);
							break;
						end
						len = cl_len[sym];
						if (len == 0 || len > held) break;
						void'(take(len));
						if (sym < 16) begin
							prev_len = sym; prev_ok = 1;
							run_out(1, sym);
						end else begin
							pend = sym;
						end
					end
				end
			end
		endfunction

		function void cmp(string name, int e, int a);
			if (e != a) begin
				$display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, e, a);
				fails++;
			end
		endfunction

		// compare one output transfer with the oldest expectation
		function void check_result(result_t got);
			result_t e;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected transfer, expected nothing, actual %p", $time, got);
				fails++;
				return;
			end
			e = exp_q.pop_front();
			checked++;
			case (e.kind)
				KIND_HEADER: n_hdr++;
				KIND_RUN: n_run++;
				default: n_err++;
			endcase
			cmp("out_kind", e.kind, got.kind);
			cmp("table_select", e.tsel, got.tsel);
			cmp("first_index", e.first, got.first);
			cmp("run_count", e.run, got.run);
			cmp("code_length", e.len, got.len);
			cmp("literal_count", e.lit, got.lit);
			cmp("distance_count", e.dcnt, got.dcnt);
			cmp("final_block", e.fin, got.fin);
			cmp("error_code", e.err, got.err);
			cmp("header_done", e.done, got.done);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = 0;
	logic [0:0] s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	hdr_scoreboard sb = new();
	int send_idle = 0;  // percent of cycles the sender holds off
	int recv_stall = 0; // percent of cycles the receiver stalls
	bit long_hold_req = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int headers_sent = 0;
	bit stream_bits[$];

	always #1 clk = ~clk;

	deflate_dynamic_header_decoder_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// receiver: random stalls plus a long hold-off counted here
	always @(negedge clk) begin
		if (long_hold_req && hold_left == 0) begin
			hold_left = 600;
			long_hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// output monitor
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.first = m_tdata[8:0];
			got.run = m_tdata[16:9];
			got.len = m_tdata[20:17];
			got.lit = m_tdata[29:21];
			got.dcnt = m_tdata[35:30];
			got.fin = m_tdata[36];
			got.err = m_tdata[39:37];
			got.kind = kind_t'(m_tuser[1:0]);
			got.tsel = m_tuser[2];
			got.done = m_tlast;
			sb.check_result(got);
		end
	end

	initial begin
		#4000000;
		$display("timeout with %0d transfers still expected", sb.exp_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// one byte transfer; valid stays high across back-to-back bytes
	task automatic send_byte(bit [7:0] b, bit st);
		if ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = b;
		s_tuser = st;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, st);
		bytes_sent++;
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (sb.exp_q.size() > 0) @(negedge clk);
	endtask

	function automatic void put_bits(int v, int n);
		for (int i = 0; i < n; i++) stream_bits.push_back((v >> i) & 1);
	endfunction

	// builds one header as a bit stream and sends it
	task automatic send_header(hdr_mode_t mode);
		int hc, k, i, d, s, total, pos, n, lim, guard, code;
		int dep[$];
		int avail[$];
		int used[$];
		int ln[CL_SYMS];
		int cw[CL_SYMS];
		int cnt[8];
		int nxt[8];
		bit prev;
		bit [7:0] b;
		stream_bits.delete();
		foreach (ln[j]) begin ln[j] = 0; cw[j] = 0; end
		put_bits($urandom_range(0, 1), 1);
		if (mode == HM_BADTYPE) begin
			case ($urandom_range(0, 2))
				0: put_bits(0, 2);
				1: put_bits(1, 2);
				default: put_bits(3, 2);
			endcase
		end else begin
			put_bits(2, 2);
		end
		total = 0;
		if (mode == HM_MAXCNT) begin
			put_bits(31, 5); put_bits(31, 5); total = 288 + 32;
		end else begin
			n = $urandom_range(0, 31); put_bits(n, 5); total = 257 + n;
			n = $urandom_range(0, 31); put_bits(n, 5); total += 1 + n;
		end
		hc = ($urandom_range(0, 1) || mode == HM_REP_FIRST) ? 15 : $urandom_range(0, 15);
		put_bits(hc, 4);
		for (i = 0; i < hc + 4; i++) avail.push_back(cl_order_f(i[4:0]));
		avail.shuffle();
		if (mode == HM_REP_FIRST) begin
			ln[16] = 1; ln[0] = 2; ln[18] = 2;
		end else if (mode == HM_OVERSUB) begin
			for (i = 0; i < 3; i++) ln[avail[i]] = 1;
		end else if (mode != HM_EMPTY) begin
			k = $urandom_range(2, (avail.size() < 10) ? avail.size() : 10);
			dep.push_back(0);
			guard = 0;
			while (dep.size() < k && guard < 200) begin
				i = $urandom_range(0, dep.size() - 1);
				guard++;
				if (dep[i] >= 7) continue;
				d = dep[i];
				dep.delete(i);
				dep.push_back(d + 1);
				dep.push_back(d + 1);
			end
			foreach (dep[j]) ln[avail[j]] = dep[j];
		end
		for (i = 0; i < hc + 4; i++) put_bits(ln[cl_order_f(i[4:0])], 3);
		// canonical codes
		foreach (cnt[j]) begin cnt[j] = 0; nxt[j] = 0; end
		for (i = 0; i < CL_SYMS; i++) if (ln[i] != 0) begin cnt[ln[i]]++; used.push_back(i); end
		code = 0;
		for (i = 1; i < 8; i++) begin code = (code + cnt[i - 1]) << 1; nxt[i] = code; end
		for (i = 0; i < CL_SYMS; i++) if (ln[i] != 0) cw[i] = nxt[ln[i]]++;
		// code length symbols, fitted to the header size
		pos = 0; prev = 0; guard = 0;
		if (mode == HM_REP_FIRST) begin
			for (i = ln[16] - 1; i >= 0; i--) stream_bits.push_back((cw[16] >> i) & 1);
			put_bits($urandom_range(0, 3), 2);
		end
		while (used.size() > 0 && pos < total && guard < 400) begin
			guard++;
			s = used[$urandom_range(0, used.size() - 1)];
			if (s == 16) begin
				if (!prev) continue;
				lim = 6;
				n = 3;
			end else if (s == 17) begin
				lim = 10; n = 3;
			end else if (s == 18) begin
				lim = 138; n = 11;
			end else begin
				lim = 1; n = 1;
			end
			if (mode != HM_OVERRUN && n > total - pos) continue;
			if (mode == HM_OVERRUN && total - pos < 30 && s >= 16) lim = n + 7;
			else if (lim > total - pos) lim = total - pos;
			n = $urandom_range(n, lim);
			for (i = ln[s] - 1; i >= 0; i--) stream_bits.push_back((cw[s] >> i) & 1);
			if (s == 16) put_bits(n - 3, 2);
			else if (s == 17) put_bits(n - 3, 3);
			else if (s == 18) put_bits(n - 11, 7);
			pos += n;
			prev = 1;
		end
		if (mode == HM_EMPTY) put_bits($urandom_range(0, 255), 8);
		while (stream_bits.size() % 8 != 0) stream_bits.push_back($urandom_range(0, 1));
		n = stream_bits.size() / 8;
		if (mode == HM_CUT) n = $urandom_range(1, n);
		for (i = 0; i < n; i++) begin
			for (int j = 0; j < 8; j++) b[j] = stream_bits[8 * i + j];
			send_byte(b, i == 0);
		end
		headers_sent++;
	endtask

	initial begin
		int pick;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: unsupported types, an ignored byte, broken code-length codes, a leading repeat
		send_header(HM_BADTYPE);
		send_header(HM_BADTYPE);
		send_header(HM_BADTYPE);
		send_byte(8'hFF, 0);
		send_header(HM_OVERSUB);
		send_header(HM_EMPTY);
		send_header(HM_REP_FIRST);
		drain();

		// random: idling profile moves through four phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 59; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 59; long_hold_req = 1; end
				default: begin send_idle = 35; recv_stall = 35; end
			endcase
			while (bytes_sent < 10 + 90 * (ph + 1)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) send_header(HM_NORMAL);
				else if (pick < 74) send_header(HM_BADTYPE);
				else if (pick < 78) send_header(HM_OVERSUB);
				else if (pick < 81) send_header(HM_EMPTY);
				else if (pick < 84) send_header(HM_REP_FIRST);
				else if (pick < 89) send_header(HM_OVERRUN);
				else if (pick < 92) send_header(HM_MAXCNT);
				else if (pick < 96) send_header(HM_CUT);
				else send_byte($urandom_range(0, 255), $urandom_range(0, 1));
			end
			// let every expected result out before the profile changes
			drain();
		end

		recv_stall = 0;
		drain();
		repeat (3000) @(posedge clk);
		$display("sent %0d bytes in %0d headers; checked %0d transfers", bytes_sent,
			headers_sent, sb.checked);
		$display("headers %0d, runs %0d, errors %0d", sb.n_hdr, sb.n_run, sb.n_err);
		if (sb.fails == 0 && sb.exp_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
